[sv/sjmc_pkg.sv]
// Shared widths and status codes for the sorted join match counter.
`default_nettype none

package sjmc_pkg;

    // Run counter width; the run product is 2*COUNT_WIDTH bits and must fit TOTAL_W.
    localparam int COUNT_WIDTH = 32;
    localparam int KEY_W       = 60;
    localparam int TOTAL_W     = 64;
    localparam int STATUS_W    = 2;

    localparam int S_TDATA_W   = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((TOTAL_W + STATUS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - TOTAL_W - STATUS_W;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

    localparam logic SIDE_DB    = 1'b0;
    localparam logic SIDE_QUERY = 1'b1;

endpackage

`default_nettype wire

[sv/sorted_join_match_count_unit.sv]
// Top level of the sorted join match counter: run tracking, product and total pipeline.
//
//  channel | dir | payload                                   | marker
//  --------+-----+-------------------------------------------+-------------------------
//  s_*     | in  | tdata: key[59:0]; tuser: side             | tlast: final_item
//  m_*     | out | tdata: match_total[63:0], status[65:64]   | one beat per final_item
//
//  One input beat per cycle. A beat passes the input register, the run tracker
//  (60-bit compare, count increment), the operand register, the 32x32 product
//  register and the 64-bit saturating accumulator into the output register.
//  rst_n clears all run state, the total and every valid bit at once.
//  The pipeline stops only while a result waits in the output register with
//  m_tready low and the next final beat has reached the accumulator; other
//  beats keep flowing.
`default_nettype none

module sorted_join_match_count_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sjmc_pkg::S_TDATA_W-1:0]  s_tdata,   // key[59:0], zero fill
    input  logic                            s_tuser,   // side
    input  logic                            s_tlast,   // final_item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sjmc_pkg::M_TDATA_W-1:0]  m_tdata    // match_total[63:0], status[65:64]
);

    localparam int CW = sjmc_pkg::COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // input register
    logic                           in_valid_reg, in_valid_next;
    logic                           in_side_reg;
    logic [sjmc_pkg::KEY_W-1:0]     in_key_reg;
    logic                           in_last_reg;

    // run tracker state
    logic [sjmc_pkg::KEY_W-1:0]     cur_key_reg, cur_key_next;
    logic                           have_key_reg, have_key_next;
    logic [CW-1:0]                  db_cnt_reg, db_cnt_next;
    logic [CW-1:0]                  qr_cnt_reg, qr_cnt_next;
    logic [sjmc_pkg::STATUS_W-1:0]  err_reg, err_next;

    // multiplier operand stage
    logic                           p1_valid_reg, p1_valid_next;
    logic                           p1_last_reg;
    logic [sjmc_pkg::STATUS_W-1:0]  p1_err_reg;
    logic [CW-1:0]                  p1_a_reg, p1_b_reg;

    // product stage
    logic                           p2_valid_reg, p2_valid_next;
    logic                           p2_last_reg;
    logic [sjmc_pkg::STATUS_W-1:0]  p2_err_reg;
    logic [sjmc_pkg::TOTAL_W-1:0]   p2_prod_reg, p2_prod_next;

    // accumulator and output register
    logic [sjmc_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic                           sum_ovf_reg, sum_ovf_next;
    logic                           out_valid_reg, out_valid_next;
    logic [sjmc_pkg::TOTAL_W-1:0]   out_total_reg, out_total_next;
    logic [sjmc_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    logic                           hold;
    logic                           adv;
    logic                           out_order;
    logic                           brk;
    logic [CW-1:0]                  db_base, qr_base;
    logic [CW-1:0]                  db_upd, qr_upd;
    logic                           cnt_sat;
    logic [sjmc_pkg::STATUS_W-1:0]  err_upd;
    logic                           mul_req;
    logic [CW-1:0]                  mul_a, mul_b;
    logic [sjmc_pkg::TOTAL_W:0]     sum_w;
    logic                           sum_ovf;
    logic [sjmc_pkg::TOTAL_W-1:0]   tot_new;

    // stop only when the next final beat would overwrite a result the sink holds off
    assign hold     = out_valid_reg && !m_tready && p2_valid_reg && p2_last_reg;
    assign adv      = !hold;
    assign s_tready = adv;

    // run tracker
    always_comb
    begin
        out_order = have_key_reg && (in_key_reg < cur_key_reg);
        brk       = have_key_reg && !out_order && (in_key_reg != cur_key_reg);
        db_base   = brk ? '0 : db_cnt_reg;
        qr_base   = brk ? '0 : qr_cnt_reg;
        db_upd    = db_base;
        qr_upd    = qr_base;
        cnt_sat   = 1'b0;
        if (!out_order)
        begin
            if (in_side_reg == sjmc_pkg::SIDE_DB)
            begin
                if (db_base == CNT_MAX)
                    cnt_sat = 1'b1;
                else
                    db_upd = db_base + 1'b1;
            end
            else
            begin
                if (qr_base == CNT_MAX)
                    cnt_sat = 1'b1;
                else
                    qr_upd = qr_base + 1'b1;
            end
        end

        if (out_order)
            err_upd = sjmc_pkg::ST_ORDER;
        else if (cnt_sat && err_reg == sjmc_pkg::ST_OK)
            err_upd = sjmc_pkg::ST_OVF;
        else
            err_upd = err_reg;

        // a value change closes the old run; a final beat closes the current one
        mul_req = brk || in_last_reg;
        mul_a   = brk ? db_cnt_reg : db_upd;
        mul_b   = brk ? qr_cnt_reg : qr_upd;

        cur_key_next  = cur_key_reg;
        have_key_next = have_key_reg;
        db_cnt_next   = db_cnt_reg;
        qr_cnt_next   = qr_cnt_reg;
        err_next      = err_reg;
        if (adv && in_valid_reg)
        begin
            if (in_last_reg)
            begin
                cur_key_next  = '0;
                have_key_next = 1'b0;
                db_cnt_next   = '0;
                qr_cnt_next   = '0;
                err_next      = sjmc_pkg::ST_OK;
            end
            else
            begin
                if (!out_order)
                    cur_key_next = in_key_reg;
                have_key_next = 1'b1;
                db_cnt_next   = db_upd;
                qr_cnt_next   = qr_upd;
                err_next      = err_upd;
            end
        end
    end

    // saturating accumulator
    always_comb
    begin
        sum_w   = {1'b0, total_reg} + {1'b0, p2_prod_reg};
        sum_ovf = sum_w[sjmc_pkg::TOTAL_W];
        tot_new = sum_ovf ? '1 : sum_w[sjmc_pkg::TOTAL_W-1:0];

        total_next      = total_reg;
        sum_ovf_next    = sum_ovf_reg;
        out_total_next  = out_total_reg;
        out_status_next = out_status_reg;
        if (adv && p2_valid_reg)
        begin
            if (p2_last_reg)
            begin
                total_next     = '0;
                sum_ovf_next   = 1'b0;
                out_total_next = tot_new;
                if (p2_err_reg == sjmc_pkg::ST_ORDER)
                    out_status_next = sjmc_pkg::ST_ORDER;
                else if (p2_err_reg == sjmc_pkg::ST_OVF || sum_ovf_reg || sum_ovf)
                    out_status_next = sjmc_pkg::ST_OVF;
                else
                    out_status_next = sjmc_pkg::ST_OK;
            end
            else
            begin
                total_next   = tot_new;
                sum_ovf_next = sum_ovf_reg || sum_ovf;
            end
        end
    end

    assign in_valid_next  = adv ? s_tvalid : in_valid_reg;
    assign p1_valid_next  = adv ? (in_valid_reg && mul_req) : p1_valid_reg;
    assign p2_valid_next  = adv ? p1_valid_reg : p2_valid_reg;
    assign p2_prod_next   = sjmc_pkg::TOTAL_W'(p1_a_reg) * sjmc_pkg::TOTAL_W'(p1_b_reg);
    assign out_valid_next = (out_valid_reg && !m_tready) || (adv && p2_valid_reg && p2_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cur_key_reg   <= '0;
            have_key_reg  <= 1'b0;
            db_cnt_reg    <= '0;
            qr_cnt_reg    <= '0;
            err_reg       <= sjmc_pkg::ST_OK;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            total_reg     <= '0;
            sum_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            cur_key_reg   <= cur_key_next;
            have_key_reg  <= have_key_next;
            db_cnt_reg    <= db_cnt_next;
            qr_cnt_reg    <= qr_cnt_next;
            err_reg       <= err_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            total_reg     <= total_next;
            sum_ovf_reg   <= sum_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_side_reg <= s_tuser;
            in_key_reg  <= s_tdata[sjmc_pkg::KEY_W-1:0];
            in_last_reg <= s_tlast;
            p1_last_reg <= in_last_reg;
            p1_err_reg  <= err_upd;
            p1_a_reg    <= mul_a;
            p1_b_reg    <= mul_b;
            p2_last_reg <= p1_last_reg;
            p2_err_reg  <= p1_err_reg;
            p2_prod_reg <= p2_prod_next;
        end
        out_total_reg  <= out_total_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{sjmc_pkg::M_PAD_W{1'b0}}, out_status_reg, out_total_reg};

endmodule

`default_nettype wire

[sv/sjmc_checker.sv]
// Port-level checks for the sorted join match counter, bound to the top level.
`default_nettype none

module sjmc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [sjmc_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire logic                            s_tuser,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sjmc_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ST_LO = sjmc_pkg::TOTAL_W;
    localparam int ST_HI = sjmc_pkg::TOTAL_W + sjmc_pkg::STATUS_W - 1;

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a result beat has zero fill bits above the status and never the unused status code 3
    a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[sjmc_pkg::M_TDATA_W-1:ST_HI+1] == '0
                     && m_tdata[ST_HI:ST_LO] != 2'd3)
        else $error("bad status or fill bits in result beat");

endmodule

bind sorted_join_match_count_unit sjmc_checker u_sjmc_checker (.*);

`default_nettype wire

[bench/tb.sv]
// Testbench for the sorted join match counter: directed and random streams, scoreboard check.
`timescale 1ns / 100ps

module tb;

    localparam int KEY_W       = sjmc_pkg::KEY_W;
    localparam int COUNT_WIDTH = sjmc_pkg::COUNT_WIDTH;
    localparam int TOTAL_W     = sjmc_pkg::TOTAL_W;
    localparam int STATUS_W    = sjmc_pkg::STATUS_W;
    localparam int S_TDATA_W   = sjmc_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = sjmc_pkg::M_TDATA_W;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 16;
    localparam int RANDOM_BEATS = 1250;
    localparam int MIN_STREAMS = 40;

    localparam logic [KEY_W-1:0]       KEY_TOP   = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam logic [TOTAL_W-1:0]     TOTAL_TOP = '1;

    typedef struct packed {
        logic [TOTAL_W-1:0]  match_total;
        logic [STATUS_W-1:0] status;
    } join_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // join state mirrored by the predictor
    logic [KEY_W-1:0]       run_key;
    logic                   run_open;
    logic [COUNT_WIDTH-1:0] db_count;
    logic [COUNT_WIDTH-1:0] query_count;
    logic [TOTAL_W-1:0]     pair_total;
    logic [STATUS_W-1:0]    join_status;

    join_result_t totals_pending[$];
    int error_count = 0;
    int burst_left = 0;
    int beats_sent = 0;
    int idle_cycles = 0;

    sorted_join_match_count_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_join();
        run_key     = '0;
        run_open    = 1'b0;
        db_count    = '0;
        query_count = '0;
        pair_total  = '0;
        join_status = sjmc_pkg::ST_OK;
    endtask

    function automatic void enqueue_total(input join_result_t res);
        totals_pending = {totals_pending, res};
    endfunction

    function automatic void flag_saturation();
        if (join_status == sjmc_pkg::ST_OK)
            join_status = sjmc_pkg::ST_OVF;
    endfunction

    function automatic void close_run();
        logic [2*TOTAL_W-1:0] product;
        logic [TOTAL_W:0]     sum;
        product = {{(2*TOTAL_W-COUNT_WIDTH){1'b0}}, db_count}
                * {{(2*TOTAL_W-COUNT_WIDTH){1'b0}}, query_count};
        if (product > {{TOTAL_W{1'b0}}, TOTAL_TOP})
        begin
            pair_total = TOTAL_TOP;
            flag_saturation();
        end
        else
        begin
            sum = {1'b0, pair_total} + {1'b0, product[TOTAL_W-1:0]};
            if (sum[TOTAL_W])
            begin
                pair_total = TOTAL_TOP;
                flag_saturation();
            end
            else
                pair_total = sum[TOTAL_W-1:0];
        end
        db_count    = '0;
        query_count = '0;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] cnt);
        if (cnt == COUNT_TOP)
        begin
            flag_saturation();
            return cnt;
        end
        return cnt + 1'b1;
    endfunction

    // Advance the join state by one beat; emit the total on a final beat.
    task automatic predict_join(input logic side, input logic [KEY_W-1:0] key,
                                input logic last, output bit emit,
                                output join_result_t res);
        emit = 1'b0;
        res  = '0;
        if (run_open && key < run_key)
            join_status = sjmc_pkg::ST_ORDER;
        else
        begin
            if (run_open && key != run_key)
                close_run();
            run_key  = key;
            run_open = 1'b1;
            if (side == sjmc_pkg::SIDE_DB)
                db_count = bump_count(db_count);
            else
                query_count = bump_count(query_count);
        end
        if (last)
        begin
            close_run();
            res.match_total = pair_total;
            res.status      = join_status;
            emit = 1'b1;
            clear_join();
        end
    endtask

    task automatic send_beat(input logic side, input logic [KEY_W-1:0] key, input logic last);
        bit emit;
        join_result_t res;
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 40)) @(negedge clk);
            else
                repeat ($urandom_range(1, 4)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-KEY_W){1'b0}}, key};
        s_tuser  = side;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_join(side, key, last, emit, res);
        if (emit)
            enqueue_total(res);
        burst_left--;
        beats_sent++;
        @(negedge clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    // One pair of merged streams with nondecreasing keys; noisy streams drop keys backward.
    task automatic run_stream(input int len, input bit noisy);
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] bad_key;
        logic [63:0]      next_key;
        logic [63:0]      step;
        int               pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            key = KEY_W'($urandom_range(0, 100));
        else if (pick == 1)
            key = random_key() >> $urandom_range(0, KEY_W - 1);
        else
            key = KEY_TOP - KEY_W'($urandom_range(0, 1000));
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 19);
            if (i > 0)
            begin
                if (pick < 10)
                    step = '0;
                else if (pick < 17)
                    step = 64'($urandom_range(1, 3));
                else
                    step = {32'd0, $urandom} << $urandom_range(0, 8);
                next_key = {4'd0, key} + step;
                key = (next_key > {4'd0, KEY_TOP}) ? KEY_TOP : next_key[KEY_W-1:0];
            end
            if (noisy && i > 0 && key != '0 && $urandom_range(0, 5) == 0)
            begin
                bad_key = KEY_W'({4'd0, random_key()} % {4'd0, key});
                send_beat(1'($urandom_range(0, 1)), bad_key, i == len - 1);
            end
            else
                send_beat(1'($urandom_range(0, 1)), key, i == len - 1);
        end
    endtask

    task automatic test_directed_runs();
        // lone item: no partner, nothing matches
        send_beat(sjmc_pkg::SIDE_DB, '0, 1'b1);
        // one pair at the top key
        send_beat(sjmc_pkg::SIDE_DB, KEY_TOP, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, KEY_TOP, 1'b1);
        // pairs at both key extremes
        send_beat(sjmc_pkg::SIDE_QUERY, '0, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, '0, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, KEY_TOP, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, KEY_TOP, 1'b1);
        // runs of several: 3 x 2 plus 1 x 1
        send_beat(sjmc_pkg::SIDE_DB, 60'd7, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd7, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, 60'd7, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd7, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, 60'd7, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd8, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, 60'd9, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd9, 1'b1);
    endtask

    task automatic test_out_of_order();
        // backward key mid-stream is skipped, run stays open
        send_beat(sjmc_pkg::SIDE_DB, 60'd100, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd50, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'd100, 1'b1);
        // backward key on the final beat still closes the run
        send_beat(sjmc_pkg::SIDE_DB, 60'h555_5555_5555_5555, 1'b0);
        send_beat(sjmc_pkg::SIDE_QUERY, 60'h555_5555_5555_5555, 1'b0);
        send_beat(sjmc_pkg::SIDE_DB, 60'h2AA_AAAA_AAAA_AAAA, 1'b1);
    endtask

    task automatic test_random_streams();
        int streams;
        int start_beats;
        streams = 0;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS || streams < MIN_STREAMS)
        begin
            if ($urandom_range(0, 15) == 0)
                run_stream($urandom_range(60, 200), $urandom_range(0, 6) == 0);
            else
                run_stream($urandom_range(1, 30), $urandom_range(0, 6) == 0);
            streams++;
        end
    endtask

    // Receiver: phases of no stall, scattered stalls and long stalls.
    initial
    begin
        int stall_mode;
        int stall_left;
        int phase_left;
        stall_mode = 0;
        stall_left = 0;
        phase_left = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (stall_mode == 1)
                m_tready = ($urandom_range(0, 3) != 0);
            else if (stall_mode == 2 && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 20);
            end
            else
                m_tready = 1'b1;
        end
    end

    // Compare each result beat with the oldest pending total.
    always @(posedge clk)
    begin
        join_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (totals_pending.size() == 0)
            begin
                error_count++;
                $error("unexpected result beat: m_tdata=%h", m_tdata);
            end
            else
            begin
                want = totals_pending.pop_front();
                if (m_tdata[TOTAL_W-1:0] !== want.match_total)
                begin
                    error_count++;
                    $error("match_total: expected %0d, got %0d",
                           want.match_total, m_tdata[TOTAL_W-1:0]);
                end
                if (m_tdata[TOTAL_W +: STATUS_W] !== want.status)
                begin
                    error_count++;
                    $error("status: expected %0d, got %0d",
                           want.status, m_tdata[TOTAL_W +: STATUS_W]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        clear_join();
        #1 rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_runs();
        test_out_of_order();
        test_random_streams();
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (totals_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
